// ===== design/hpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared opcodes, rounding modes and format constants for the half-precision
// converter. No dependencies.
package hpc_pkg;

   typedef enum logic [1:0] {
      OP_H2S  = 2'd0,
      OP_S2H  = 2'd1,
      OP_D2H  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RM_RNE = 2'd0,
      RM_RTZ = 2'd1,
      RM_RTP = 2'd2,
      RM_RTN = 2'd3
   } round_mode_type;

   localparam int OPERAND_W = 64;
   localparam int RESULT_W  = 32;
   localparam int HALF_W    = 16;
   localparam int FRAC_W    = 52;  // common fraction width after alignment
   localparam int EXP_W     = 13;  // signed half exponent before range checks

   localparam logic [HALF_W-1:0] HALF_INF     = 16'h7C00;
   localparam logic [HALF_W-1:0] HALF_NAN     = 16'h7DFF;
   localparam logic [HALF_W-1:0] HALF_MAX_FIN = 16'h7BFF;

   // Half exponent = source exponent - bias + 15.
   localparam logic [EXP_W-1:0] SGL_REBIAS = 13'd112;
   localparam logic [EXP_W-1:0] DBL_REBIAS = 13'd1008;

endpackage

// ===== design/half_precision_converter.sv =====
`timescale 1ns / 1ps
// Converts IEEE binary16 to binary32 and binary32/binary64 to binary16 bit
// patterns. One item is accepted every cycle unless back-pressure stalls the
// pipeline; its result passes from the input register through the conversion
// logic into the result register, which presents it on the response channel.
// Back-pressure from rsp_ready reaches req_ready combinationally through both
// stages, so a full pipeline keeps streaming at one item per cycle while
// rsp_ready is high.
module half_precision_converter
   import hpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [OPERAND_W-1:0] req_operand_bits,
   input  logic [1:0]           req_round_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RESULT_W-1:0]  rsp_result_bits
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   opcode_type            in_opcode_ff;
   logic [OPERAND_W-1:0]  in_operand_ff;
   round_mode_type        in_round_ff;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [RESULT_W-1:0]   out_result_ff;
   logic [RESULT_W-1:0]   out_result_in;

   logic                  out_ready;
   logic                  in_load;
   logic                  out_load;
   logic [RESULT_W-1:0]   widen_bits;
   logic [HALF_W-1:0]     narrow_bits;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_ready;
   assign in_load   = req_valid && req_ready;
   assign out_load  = in_valid_ff && out_ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_ready);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   hpc_widen u_widen (
      .half_bits   (in_operand_ff[HALF_W-1:0]),
      .single_bits (widen_bits)
   );

   hpc_narrow u_narrow (
      .operand_bits (in_operand_ff),
      .is_double    (in_opcode_ff == OP_D2H),
      .round_mode   (in_round_ff),
      .half_bits    (narrow_bits)
   );

   always_comb begin
      case (in_opcode_ff)
         OP_H2S:  out_result_in = widen_bits;
         OP_S2H:  out_result_in = {16'd0, narrow_bits};
         OP_D2H:  out_result_in = {16'd0, narrow_bits};
         default: out_result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_opcode_ff  <= opcode_type'(req_opcode);
         in_operand_ff <= req_operand_bits;
         in_round_ff   <= round_mode_type'(req_round_mode);
      end
      if (out_load) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_bits = out_result_ff;

`ifndef ASSERT_OFF
   a_narrow_upper_zero: assert property (@(posedge clock) disable iff (reset)
      out_load && (in_opcode_ff == OP_S2H || in_opcode_ff == OP_D2H)
      |=> rsp_valid && rsp_result_bits[31:16] == 16'd0)
      else $error("narrowed item has nonzero upper half");

   a_unused_op_zero: assert property (@(posedge clock) disable iff (reset)
      out_load && in_opcode_ff == OP_NONE |=> rsp_result_bits == '0)
      else $error("unused opcode gave nonzero result");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(in_operand_ff))
      else $error("input stage lost a stalled item");
`endif

endmodule

// ===== design/hpc_widen.sv =====
`timescale 1ns / 1ps
// Half to single widening, combinational. Exact; subnormals are normalized.
// Depends on hpc_pkg.
module hpc_widen
   import hpc_pkg::*;
(
   input  logic [HALF_W-1:0]   half_bits,
   output logic [RESULT_W-1:0] single_bits
);

   logic       sign;
   logic [4:0] ex;
   logic [9:0] man;
   logic [3:0] shift;
   logic [9:0] man_norm;
   logic [7:0] exp_norm;

   assign sign = half_bits[15];
   assign ex   = half_bits[14:10];
   assign man  = half_bits[9:0];

   // Shifts needed to bring the leading one to the hidden position.
   always_comb begin
      shift = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            shift = 4'(10 - i);
         end
      end
   end

   assign man_norm = man << shift;
   assign exp_norm = 8'd113 - {4'd0, shift};

   always_comb begin
      if (ex == 5'd0) begin
         if (man == 10'd0) begin
            single_bits = {sign, 31'd0};
         end else begin
            single_bits = {sign, exp_norm, man_norm, 13'd0};
         end
      end else if (ex == 5'h1F) begin
         // keep NaN payload in the low bits, unshifted
         single_bits = {sign, 8'hFF, 13'd0, man};
      end else begin
         single_bits = {sign, {3'd0, ex} + 8'd112, man, 13'd0};
      end
   end

endmodule

// ===== design/hpc_narrow.sv =====
`timescale 1ns / 1ps
// Single or double to half narrowing, combinational. Both sources are aligned
// to a 52-bit fraction so one rounding path serves both. Depends on hpc_pkg.
module hpc_narrow
   import hpc_pkg::*;
(
   input  logic [OPERAND_W-1:0] operand_bits,
   input  logic                 is_double,
   input  round_mode_type       round_mode,
   output logic [HALF_W-1:0]    half_bits
);

   logic                    neg;
   logic                    exp_zero;
   logic                    exp_max;
   logic [FRAC_W-1:0]       frac;
   logic signed [EXP_W-1:0] e;
   logic                    to_finite;
   logic [3:0]              sub_shift;
   logic [10:0]             sub_bits;
   logic [10:0]             sub_man;
   logic [14:0]             norm_trunc;
   logic [41:0]             low;
   logic                    round_up;
   logic [14:0]             norm_res;
   logic [HALF_W-1:0]       sgn;

   always_comb begin
      if (is_double) begin
         neg      = operand_bits[63];
         exp_zero = (operand_bits[62:52] == 11'd0);
         exp_max  = (operand_bits[62:52] == 11'h7FF);
         frac     = operand_bits[51:0];
         e        = $signed({2'd0, operand_bits[62:52]} - DBL_REBIAS);
      end else begin
         neg      = operand_bits[31];
         exp_zero = (operand_bits[30:23] == 8'd0);
         exp_max  = (operand_bits[30:23] == 8'hFF);
         frac     = {operand_bits[22:0], 29'd0};
         e        = $signed({5'd0, operand_bits[30:23]} - SGL_REBIAS);
      end
   end

   assign sgn = {neg, 15'd0};

   assign to_finite = (round_mode == RM_RTZ) || (round_mode == RM_RTP && neg)
                      || (round_mode == RM_RTN && !neg);

   // Subnormal result: shift hidden bit and top fraction right by 1 - e, round
   // half up on the last bit dropped; the increment may carry into the
   // smallest normal.
   assign sub_shift = 4'(-e);
   assign sub_bits  = {1'b1, frac[51:42]} >> sub_shift;
   assign sub_man   = {1'b0, sub_bits[10:1]} + {10'd0, sub_bits[0]};

   assign norm_trunc = {e[4:0], frac[51:42]};
   assign low        = frac[41:0];

   always_comb begin
      case (round_mode)
         RM_RNE:  round_up = low[41] && ((low[40:0] != 41'd0) || norm_trunc[0]);
         RM_RTP:  round_up = !neg && (low != 42'd0);
         RM_RTN:  round_up = neg && (low != 42'd0);
         default: round_up = 1'b0;
      endcase
   end

   // a carry out of the mantissa steps into the exponent, possibly infinity
   assign norm_res = norm_trunc + {14'd0, round_up};

   always_comb begin
      if (exp_zero) begin
         half_bits = sgn;
      end else if (exp_max) begin
         half_bits = sgn | ((frac != 52'd0) ? HALF_NAN : HALF_INF);
      end else if (e >= 13'sd31) begin
         half_bits = sgn | (to_finite ? HALF_MAX_FIN : HALF_INF);
      end else if (e < -13'sd10) begin
         half_bits = sgn;
      end else if (e <= 13'sd0) begin
         half_bits = sgn | {5'd0, sub_man};
      end else begin
         half_bits = sgn | {1'b0, norm_res};
      end
   end

endmodule

// ===== bench/hpc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the half-precision converter: predicts each result from
// accepted request items and compares it with the response channel. Uses hpc_pkg.
module hpc_result_checker
   import hpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [OPERAND_W-1:0] req_operand_bits,
   input  logic [1:0]           req_round_mode,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [RESULT_W-1:0]  rsp_result_bits,
   output int                   mismatch_count,
   output int                   awaited_count,
   output int                   checked_count
);

   logic [RESULT_W-1:0] awaited_results[$];
   int errs = 0;
   int checked = 0;

   // Narrow a binary32 or binary64 value to a half pattern. fb is the stored
   // fraction width of the source.
   function automatic logic [HALF_W-1:0] narrow_half(input logic neg, input int expf,
                                                     input int expmax, input int bias,
                                                     input logic [63:0] frac, input int fb,
                                                     input round_mode_type rm);
      logic [HALF_W-1:0] s;
      logic [63:0] low;
      logic [63:0] halfbit;
      logic [63:0] mant;
      logic [31:0] h;
      logic finite_cap;
      int drop;
      int e;
      int sh;
      s = neg ? 16'h8000 : 16'h0000;
      drop = fb - 10;
      halfbit = 64'd1 << (drop - 1);
      low = frac & ((64'd1 << drop) - 64'd1);
      // input subnormals flush to signed zero
      if (expf == 0)
         return s;
      if (expf == expmax)
         return (frac != 0) ? (s | HALF_NAN) : (s | HALF_INF);
      e = expf - bias + 15;
      if (e >= 31) begin
         finite_cap = (rm == RM_RTZ) || (rm == RM_RTP && neg) || (rm == RM_RTN && !neg);
         return s | (finite_cap ? HALF_MAX_FIN : HALF_INF);
      end
      if (e <= 0) begin
         if (e < -10)
            return s;
         // subnormal result: round half up whatever the mode, may carry to normal
         mant = frac | (64'd1 << fb);
         sh = fb - 9 - e;
         h = 32'(mant >> sh) + 32'((mant >> (sh - 1)) & 64'd1);
         return s | h[15:0];
      end
      h = (32'(e) << 10) + 32'(frac >> drop);
      case (rm)
         RM_RNE: begin
            if ((low & halfbit) != 0 && ((low & ~halfbit) != 0 || h[0]))
               h = h + 1;
         end
         RM_RTP: begin
            if (!neg && low != 0)
               h = h + 1;
         end
         RM_RTN: begin
            if (neg && low != 0)
               h = h + 1;
         end
         default: ;
      endcase
      return s | h[15:0];
   endfunction

   function automatic logic [RESULT_W-1:0] predicted_bits(input opcode_type op,
                                                          input logic [63:0] src,
                                                          input round_mode_type rm);
      logic [15:0] hw;
      logic [4:0] hexp;
      logic [10:0] hman;
      logic [RESULT_W-1:0] r;
      int k;
      r = '0;
      case (op)
         OP_H2S: begin
            hw = src[15:0];
            hexp = hw[14:10];
            hman = {1'b0, hw[9:0]};
            k = 0;
            if (hexp == 5'd0) begin
               if (hman == 11'd0) begin
                  r = {hw[15], 31'd0};
               end else begin
                  // normalize the subnormal half
                  while (!hman[10]) begin
                     hman = hman << 1;
                     k++;
                  end
                  r = {hw[15], 8'(113 - k), hman[9:0], 13'd0};
               end
            end else if (hexp == 5'h1F) begin
               // payload goes to the low bits, unshifted
               r = {hw[15], 8'hFF, 13'd0, hw[9:0]};
            end else begin
               r = {hw[15], 8'({3'd0, hexp}) + 8'd112, hw[9:0], 13'd0};
            end
         end
         OP_S2H: r = {16'd0, narrow_half(src[31], int'(src[30:23]), 255, 127,
                                          {41'd0, src[22:0]}, 23, rm)};
         OP_D2H: r = {16'd0, narrow_half(src[63], int'(src[62:52]), 2047, 1023,
                                          {12'd0, src[51:0]}, 52, rm)};
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      logic [RESULT_W-1:0] want;
      if (reset) begin
         awaited_results.delete();
      end else begin
         // check first so a same-edge request never pairs with this result
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               errs++;
               $display("%0t ns: unexpected result_bits %h, expected none",
                        $time, rsp_result_bits);
            end else begin
               want = awaited_results.pop_front();
               checked++;
               if (want !== rsp_result_bits) begin
                  errs++;
                  $display("%0t ns: result_bits expected %h, actual %h",
                           $time, want, rsp_result_bits);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(predicted_bits(opcode_type'(req_opcode),
                                                     req_operand_bits,
                                                     round_mode_type'(req_round_mode)));
      end
      mismatch_count <= errs;
      awaited_count <= awaited_results.size();
      checked_count <= checked;
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for half_precision_converter: drives directed and random
// conversions with random idling and gives the verdict. Uses hpc_pkg and hpc_result_checker.
module tb_top;
   import hpc_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1425;
   localparam int LONG_HOLD    = 80;
   localparam int HOLD_AFTER   = 600;
   localparam int CYCLE_LIMIT  = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   opcode_type           req_opcode = OP_H2S;
   logic [OPERAND_W-1:0] req_operand_bits = '0;
   round_mode_type       req_round_mode = RM_RNE;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [RESULT_W-1:0]  rsp_result_bits;

   int mismatch_count;
   int awaited_count;
   int checked_count;
   int sent_count = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;

   always #CLOCK_HALF clock = ~clock;

   half_precision_converter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_operand_bits (req_operand_bits),
      .req_round_mode   (req_round_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_bits  (rsp_result_bits)
   );

   hpc_result_checker result_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_operand_bits (req_operand_bits),
      .req_round_mode   (req_round_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_bits  (rsp_result_bits),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count),
      .checked_count    (checked_count)
   );

   // Present one item after a random gap and hold it until accepted.
   task automatic offer_item(input opcode_type op, input logic [63:0] src,
                             input round_mode_type rm);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_operand_bits <= src;
      req_round_mode <= rm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   initial begin : receiver
      int stall;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER) begin
            // long back-pressure so the pipeline fills and stalls the sender
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = receiver_calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 64 == 0)
            receiver_calm = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] src;
      opcode_type op;
      round_mode_type rm;
      int pick;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // widening: zeros, subnormals, infinity, NaN payload, normals
      offer_item(OP_H2S, 64'h0000_0000_0000_0000, RM_RNE);
      offer_item(OP_H2S, 64'hFFFF_FFFF_FFFF_8000, RM_RTZ);
      offer_item(OP_H2S, 64'h0000_0000_0000_0001, RM_RTP);
      offer_item(OP_H2S, 64'h0000_0000_0000_83FF, RM_RTN);
      offer_item(OP_H2S, 64'h0000_0000_0000_7C00, RM_RNE);
      offer_item(OP_H2S, 64'h0000_0000_0000_7D55, RM_RNE);
      offer_item(OP_H2S, 64'h0000_0000_0000_3C00, RM_RNE);
      // single to half: flush, infinity, NaN, overflow by mode, tiny, subnormal
      offer_item(OP_S2H, 64'h0000_0000_807F_FFFF, RM_RNE);
      offer_item(OP_S2H, 64'h0000_0000_FF80_0000, RM_RTZ);
      offer_item(OP_S2H, 64'h0000_0000_7FC0_0001, RM_RTP);
      offer_item(OP_S2H, 64'h0000_0000_7F00_0000, RM_RNE);
      offer_item(OP_S2H, 64'h0000_0000_7F00_0000, RM_RTZ);
      offer_item(OP_S2H, 64'h0000_0000_FF00_0000, RM_RTP);
      offer_item(OP_S2H, 64'h0000_0000_7F00_0000, RM_RTN);
      offer_item(OP_S2H, 64'h0000_0000_3280_0000, RM_RTP);
      offer_item(OP_S2H, 64'h0000_0000_3380_0000, RM_RTZ);
      offer_item(OP_S2H, 64'h0000_0000_387F_F000, RM_RTZ);
      // ties under nearest even, directed rounding, carry into infinity
      offer_item(OP_S2H, 64'h0000_0000_3F80_1000, RM_RNE);
      offer_item(OP_S2H, 64'h0000_0000_3F80_3000, RM_RNE);
      offer_item(OP_S2H, 64'h0000_0000_BF80_0001, RM_RTN);
      offer_item(OP_S2H, 64'h0000_0000_477F_F000, RM_RNE);
      // double to half and the unused opcode
      offer_item(OP_D2H, 64'hFFFF_FFFF_FFFF_FFFF, RM_RTZ);
      offer_item(OP_D2H, 64'h3F0F_FFFF_FFFF_FFFF, RM_RNE);
      offer_item(OP_D2H, 64'h40EF_FFFF_FFFF_FFFF, RM_RTP);
      offer_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, RM_RTN);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
         src = {$urandom, $urandom};
         rm = round_mode_type'($urandom_range(0, 3));
         pick = $urandom_range(0, 15);
         op = (pick < 4) ? OP_H2S : (pick < 9) ? OP_S2H : (pick < 15) ? OP_D2H : OP_NONE;
         // steer exponents toward the subnormal, tiny and overflow boundaries
         case (op)
            OP_H2S: begin
               case ($urandom_range(0, 3))
                  0: src[14:10] = 5'd0;
                  1: src[14:10] = 5'h1F;
                  default: ;
               endcase
            end
            OP_S2H: begin
               case ($urandom_range(0, 7))
                  0: src[30:23] = 8'd0;
                  1: src[30:23] = 8'hFF;
                  2, 3, 4, 5: src[30:23] = 8'($urandom_range(97, 143));
                  default: ;
               endcase
               case ($urandom_range(0, 5))
                  0: src[12:0] = 13'h1000;
                  1: src[12:0] = 13'h0000;
                  2: src[22:0] = '1;
                  default: ;
               endcase
            end
            OP_D2H: begin
               case ($urandom_range(0, 7))
                  0: src[62:52] = 11'd0;
                  1: src[62:52] = 11'h7FF;
                  2, 3, 4, 5: src[62:52] = 11'($urandom_range(997, 1040));
                  default: ;
               endcase
               case ($urandom_range(0, 5))
                  0: src[41:0] = 42'h200_0000_0000;
                  1: src[41:0] = 42'h0;
                  2: src[51:0] = '1;
                  default: ;
               endcase
            end
            default: ;
         endcase
         offer_item(op, src, rm);
      end
      req_valid <= 1'b0;

      // let the last push show up in the count before draining
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d items sent, %0d results checked", sent_count, checked_count);
      $display("summary: all opcodes, rounding modes and boundary exponents exercised");
      if (mismatch_count == 0 && awaited_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
